// ===== rtl/core/srar1_pkg.sv =====
// Shared types, codes and constants for the standardized residual block.
// Used by srar1_ctrl, srar1_dp and standardized_residual_ar1; depends on nothing.
package srar1_pkg;

  localparam int DATA_W     = 32;               // Q16.16 word
  localparam int DIFF_W     = DATA_W + 1;       // exact observed - simulated
  localparam int PROD_W     = 2 * DATA_W;       // full product
  localparam int FRAC_W     = 16;               // fraction bits of Q16.16
  localparam int SCALE_W    = PROD_W - FRAC_W;  // floor of product, plus offset
  localparam int DMAG_W     = SCALE_W - 1;      // scale magnitude stays below 2^47
  localparam int QUO_W      = DATA_W + 1;       // quotient bits developed
  localparam int DIV_STEPS  = QUO_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W  = 2;

  localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_CONSTANT     = 2'd0,
    MODE_PROPORTIONAL = 2'd1,
    MODE_LINEAR       = 2'd2,
    MODE_LINEAR_AR1   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ERROR_MODE     = 2'd0,
    REG_SCALE_OFFSET   = 2'd1,
    REG_SCALE_SLOPE    = 2'd2,
    REG_AR_COEFFICIENT = 2'd3
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_PREP,
    ST_CHECK,
    ST_DIV,
    ST_SIGN,
    ST_AR_MUL,
    ST_AR_SUB,
    ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_SCALE,
    OP_PREP,
    OP_CHECK,
    OP_DIV_STEP,
    OP_SIGN,
    OP_AR_MUL,
    OP_AR_SUB,
    OP_FINISH
  } op_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] observed;
    logic signed [DATA_W-1:0] simulated;
    logic                     observed_missing;
    logic                     simulated_missing;
    logic                     series_start;
  } sample_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] residual;
    logic                     divide_fault;
  } result_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic ar_step;   // AR1 mode with a live history
  } dp_status_t;

endpackage

// ===== rtl/core/srar1_ctrl.sv =====
// Sequencer for the standardized residual block: request handshake, step order,
// divider step count and result valid. Depends on srar1_pkg.
module srar1_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  input  logic                   sample_skip,
  output logic                   sample_stall,
  output logic                   result_valid,
  input  logic                   result_stall,
  output srar1_pkg::dp_cmd_t     cmd,
  input  srar1_pkg::dp_status_t  status
);

  srar1_pkg::state_t             state, state_next;
  logic [srar1_pkg::DIV_CNT_W-1:0] div_count;
  logic                          out_free;

  assign out_free     = !result_valid || !result_stall;
  assign sample_stall = (state != srar1_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srar1_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_count <= '0;
    end else if (state == srar1_pkg::ST_CHECK) begin
      div_count <= srar1_pkg::DIV_CNT_W'(srar1_pkg::DIV_STEPS - 1);
    end else if (state == srar1_pkg::ST_DIV) begin
      div_count <= div_count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.op == srar1_pkg::OP_FINISH) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      srar1_pkg::ST_IDLE: begin
        if (sample_valid && !sample_skip) state_next = srar1_pkg::ST_MUL;
      end
      srar1_pkg::ST_MUL:    state_next = srar1_pkg::ST_SCALE;
      srar1_pkg::ST_SCALE:  state_next = srar1_pkg::ST_PREP;
      srar1_pkg::ST_PREP:   state_next = srar1_pkg::ST_CHECK;
      srar1_pkg::ST_CHECK:  state_next = srar1_pkg::ST_DIV;
      srar1_pkg::ST_DIV: begin
        if (div_count == '0) state_next = srar1_pkg::ST_SIGN;
      end
      srar1_pkg::ST_SIGN: begin
        state_next = status.ar_step ? srar1_pkg::ST_AR_MUL : srar1_pkg::ST_FINISH;
      end
      srar1_pkg::ST_AR_MUL: state_next = srar1_pkg::ST_AR_SUB;
      srar1_pkg::ST_AR_SUB: state_next = srar1_pkg::ST_FINISH;
      srar1_pkg::ST_FINISH: begin
        if (out_free) state_next = srar1_pkg::ST_IDLE;
      end
      default: state_next = srar1_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd.op = srar1_pkg::OP_NONE;
    unique case (state)
      srar1_pkg::ST_IDLE: begin
        if (sample_valid) cmd.op = srar1_pkg::OP_LOAD;
      end
      srar1_pkg::ST_MUL:    cmd.op = srar1_pkg::OP_MUL;
      srar1_pkg::ST_SCALE:  cmd.op = srar1_pkg::OP_SCALE;
      srar1_pkg::ST_PREP:   cmd.op = srar1_pkg::OP_PREP;
      srar1_pkg::ST_CHECK:  cmd.op = srar1_pkg::OP_CHECK;
      srar1_pkg::ST_DIV:    cmd.op = srar1_pkg::OP_DIV_STEP;
      srar1_pkg::ST_SIGN:   cmd.op = srar1_pkg::OP_SIGN;
      srar1_pkg::ST_AR_MUL: cmd.op = srar1_pkg::OP_AR_MUL;
      srar1_pkg::ST_AR_SUB: cmd.op = srar1_pkg::OP_AR_SUB;
      srar1_pkg::ST_FINISH: begin
        if (out_free) cmd.op = srar1_pkg::OP_FINISH;
      end
      default: cmd.op = srar1_pkg::OP_NONE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_valid_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == srar1_pkg::ST_FINISH))
    else $error("result valid rose outside the finish step");

  a_div_count_range: assert property (@(posedge clk) disable iff (rst)
    (state == srar1_pkg::ST_DIV) |-> (div_count <= srar1_pkg::DIV_CNT_W'(srar1_pkg::DIV_STEPS - 1)))
    else $error("divider step count out of range");

  a_kept_request_starts: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall && !sample_skip) |=> (state == srar1_pkg::ST_MUL))
    else $error("kept request did not start the multiply step");
`endif

endmodule

// ===== rtl/core/srar1_dp.sv =====
// Datapath for the standardized residual block: configuration registers, shared
// multiplier, restoring divider, saturation, AR1 history and result register.
// Depends on srar1_pkg.
module srar1_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [srar1_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [srar1_pkg::DATA_W-1:0]        cfg_data,
  input  srar1_pkg::sample_t                  sample,
  input  srar1_pkg::dp_cmd_t                  cmd,
  output srar1_pkg::dp_status_t               status,
  output srar1_pkg::result_t                  result
);

  localparam int DW = srar1_pkg::DATA_W;
  localparam int FW = srar1_pkg::FRAC_W;
  localparam int SW = srar1_pkg::SCALE_W;
  localparam int MW = srar1_pkg::DMAG_W;
  localparam int QW = srar1_pkg::QUO_W;
  localparam int PW = srar1_pkg::PROD_W;

  // Configuration
  srar1_pkg::mode_t          error_mode;
  logic signed [DW-1:0]      scale_offset;
  logic signed [DW-1:0]      scale_slope;
  logic signed [DW-1:0]      ar_coefficient;

  // AR history
  logic signed [DW-1:0]      previous_eta;
  logic                      history_valid;

  // Work registers
  logic signed [DW-1:0]      obs;
  logic signed [DW-1:0]      sim;
  logic signed [DW:0]        diff;
  logic signed [PW-1:0]      prod;
  logic signed [SW-1:0]      scale;
  logic [MW-1:0]             dmag;
  logic [MW-1:0]             rem;
  logic [QW-1:0]             nbits;
  logic [QW-1:0]             quo;
  logic                      neg;
  logic                      zero;
  logic                      ovf;
  logic signed [DW-1:0]      eta;
  logic signed [DW-1:0]      res;
  logic                      fault;

  // Combinational values
  logic signed [DW-1:0]      mul_a, mul_b;
  logic signed [PW-1:0]      prod_next;
  logic signed [SW-1:0]      prod_floor;
  logic signed [SW-1:0]      offset_ext;
  logic signed [SW-1:0]      scale_next;
  logic signed [SW-1:0]      scale_neg;
  logic signed [DW:0]        diff_neg;
  logic [DW-1:0]             dabs;
  logic [MW:0]               trial;
  logic [MW:0]               trial_sub;
  logic                      trial_geq;
  logic signed [DW-1:0]      eta_next;
  logic                      fault_next;
  logic signed [SW:0]        ar_diff;
  logic signed [DW-1:0]      ar_res;

  assign status.ar_step = (error_mode == srar1_pkg::MODE_LINEAR_AR1) && history_valid;

  // Shared multiplier: scale factor times simulated, or AR coefficient times history
  always_comb begin
    if (cmd.op == srar1_pkg::OP_AR_MUL) begin
      mul_a = ar_coefficient;
      mul_b = previous_eta;
    end else begin
      mul_a = (error_mode == srar1_pkg::MODE_PROPORTIONAL) ? scale_offset : scale_slope;
      mul_b = sim;
    end
  end
  assign prod_next  = mul_a * mul_b;
  assign prod_floor = $signed(prod[PW-1:FW]);
  assign offset_ext = $signed({{(SW-DW){scale_offset[DW-1]}}, scale_offset});

  always_comb begin
    unique case (error_mode)
      srar1_pkg::MODE_CONSTANT:     scale_next = offset_ext;
      srar1_pkg::MODE_PROPORTIONAL: scale_next = prod_floor;
      srar1_pkg::MODE_LINEAR,
      srar1_pkg::MODE_LINEAR_AR1:   scale_next = offset_ext + prod_floor;
      default:                      scale_next = offset_ext;
    endcase
  end

  assign scale_neg = -scale;
  assign diff_neg  = -diff;
  assign dabs      = diff[DW] ? diff_neg[DW-1:0] : diff[DW-1:0];

  // One restoring step: bring in the next dividend bit, subtract if it fits
  assign trial     = {rem, nbits[QW-1]};
  assign trial_geq = (trial >= {1'b0, dmag});
  assign trial_sub = trial - {1'b0, dmag};

  // Sign and saturate the quotient magnitude
  always_comb begin
    fault_next = 1'b0;
    if (zero) begin
      fault_next = 1'b1;
      if (diff == '0) begin
        eta_next = '0;
      end else begin
        eta_next = diff[DW] ? srar1_pkg::Q_MIN : srar1_pkg::Q_MAX;
      end
    end else if (ovf || (!neg && (quo[QW-1] || quo[QW-2]))
                 || (neg && (quo[QW-1] || (quo[QW-2] && (quo[QW-3:0] != '0))))) begin
      fault_next = 1'b1;
      eta_next   = neg ? srar1_pkg::Q_MIN : srar1_pkg::Q_MAX;
    end else begin
      eta_next = neg ? -$signed(quo[DW-1:0]) : $signed(quo[DW-1:0]);
    end
  end

  // Whitening subtraction, saturated
  assign ar_diff = $signed({{(SW+1-DW){eta[DW-1]}}, eta}) - $signed({prod_floor[SW-1], prod_floor});
  always_comb begin
    if (ar_diff[SW:DW-1] == '0 || ar_diff[SW:DW-1] == '1) begin
      ar_res = ar_diff[DW-1:0];
    end else begin
      ar_res = ar_diff[SW] ? srar1_pkg::Q_MIN : srar1_pkg::Q_MAX;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      error_mode     <= srar1_pkg::MODE_CONSTANT;
      scale_offset   <= $signed(DW'(1) << FW);
      scale_slope    <= '0;
      ar_coefficient <= '0;
    end else if (cfg_write) begin
      unique case (srar1_pkg::reg_index_t'(cfg_index))
        srar1_pkg::REG_ERROR_MODE:     error_mode     <= srar1_pkg::mode_t'(cfg_data[1:0]);
        srar1_pkg::REG_SCALE_OFFSET:   scale_offset   <= $signed(cfg_data);
        srar1_pkg::REG_SCALE_SLOPE:    scale_slope    <= $signed(cfg_data);
        srar1_pkg::REG_AR_COEFFICIENT: ar_coefficient <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // AR history: clear on series start, advance after each kept AR1 sample
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_eta  <= '0;
      history_valid <= 1'b0;
    end else if (cmd.op == srar1_pkg::OP_LOAD && sample.series_start) begin
      history_valid <= 1'b0;
    end else if (cmd.op == srar1_pkg::OP_FINISH
                 && error_mode == srar1_pkg::MODE_LINEAR_AR1) begin
      previous_eta  <= eta;
      history_valid <= 1'b1;
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      srar1_pkg::OP_NONE: ;
      srar1_pkg::OP_LOAD: begin
        obs <= sample.observed;
        sim <= sample.simulated;
      end
      srar1_pkg::OP_MUL: begin
        prod <= prod_next;
        diff <= $signed({obs[DW-1], obs}) - $signed({sim[DW-1], sim});
      end
      srar1_pkg::OP_SCALE: begin
        scale <= scale_next;
      end
      srar1_pkg::OP_PREP: begin
        dmag  <= scale[SW-1] ? scale_neg[MW-1:0] : scale[MW-1:0];
        zero  <= (scale == '0);
        neg   <= diff[DW] ^ scale[SW-1];
        rem   <= MW'(dabs[DW-1:QW-FW]);
        nbits <= {dabs[QW-FW-1:0], {FW{1'b0}}};
      end
      srar1_pkg::OP_CHECK: begin
        ovf <= (rem >= dmag);
      end
      srar1_pkg::OP_DIV_STEP: begin
        rem   <= trial_geq ? trial_sub[MW-1:0] : trial[MW-1:0];
        quo   <= {quo[QW-2:0], trial_geq};
        nbits <= {nbits[QW-2:0], 1'b0};
      end
      srar1_pkg::OP_SIGN: begin
        eta   <= eta_next;
        res   <= eta_next;
        fault <= fault_next;
      end
      srar1_pkg::OP_AR_MUL: begin
        prod <= prod_next;
      end
      srar1_pkg::OP_AR_SUB: begin
        res <= ar_res;
      end
      srar1_pkg::OP_FINISH: begin
        result.residual     <= res;
        result.divide_fault <= fault;
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_zero_scale_faults: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == srar1_pkg::OP_SIGN && zero) |=> fault)
    else $error("zero scale did not raise divide fault");

  a_ar1_sets_history: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == srar1_pkg::OP_FINISH && error_mode == srar1_pkg::MODE_LINEAR_AR1)
    |=> history_valid)
    else $error("AR1 result did not leave a valid history");
`endif

endmodule

// ===== rtl/core/standardized_residual_ar1.sv =====
// Top level of the standardized residual block with optional AR1 whitening.
// Instantiates srar1_ctrl and srar1_dp; depends on srar1_pkg.
//
// Each request carries an observed and a simulated Q16.16 sample; the block
// returns (observed - simulated) / scale in Q16.16, where the scale is the
// offset, offset * simulated, or offset + slope * simulated by error_mode, and
// in AR1 mode subtracts ar_coefficient * previous unwhitened quotient except on
// the first kept sample of a series. A request with either missing flag set
// returns nothing and only clears the history when series_start is set. A
// kept request holds the input stalled from acceptance until its final write,
// so a new request is taken only after the last one is through; the work is
// the 33-step radix-2 restoring divider and one multiply, scale, prepare,
// range check, sign and output step each, plus an AR multiply and an AR
// subtract step in AR1 mode with a live history. The result register parts
// the two sides: a finished result may wait on a stalled output while the
// next request is already in work; only the final write waits for it to drain.
// Configuration writes are taken at any time but must only change while idle.
module standardized_residual_ar1 (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  srar1_pkg::sample_t                  sample,
  // result channel
  output logic                                result_valid,
  input  logic                                result_stall,
  output srar1_pkg::result_t                  result,
  // configuration write port
  input  logic                                cfg_write,
  input  logic [srar1_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [srar1_pkg::DATA_W-1:0]        cfg_data
);

  srar1_pkg::dp_cmd_t    cmd;
  srar1_pkg::dp_status_t status;
  logic                  sample_skip;

  // Drop a request with any missing sample after the history update
  assign sample_skip = sample.observed_missing | sample.simulated_missing;

  srar1_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_skip  (sample_skip),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .status       (status)
  );

  srar1_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule

// ===== tb/standardized_residual_ar1_tb.sv =====
// Self-checking testbench for standardized_residual_ar1: directed table then random phases.
// Predicts each residual in Q16.16 with a local model; depends on srar1_pkg and the block RTL.
module standardized_residual_ar1_tb;

  localparam int unsigned REQUEST_ITEMS = 1750;  // requests to send, directed rows included
  localparam int unsigned SETTLE        = 60;    // cycles to let a request finish
  localparam int unsigned HOLD_CYCLES   = 400;   // long output hold-off
  localparam int unsigned WATCHDOG      = 4000;  // cycles without any handshake

  localparam longint RES_HI = 64'sd2147483647;
  localparam longint RES_LO = -64'sd2147483648;

  // request flag bits for the directed table: {observed_missing, simulated_missing, start}
  localparam logic [2:0] F_NONE     = 3'b000;
  localparam logic [2:0] F_OBS_MISS = 3'b100;
  localparam logic [2:0] F_SIM_MISS = 3'b010;
  localparam logic [2:0] F_START    = 3'b001;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            sample_valid;
  logic                            sample_stall;
  srar1_pkg::sample_t              sample;
  logic                            result_valid;
  logic                            result_stall;
  srar1_pkg::result_t              result;
  logic                            cfg_write;
  logic [srar1_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [srar1_pkg::DATA_W-1:0]    cfg_data;

  standardized_residual_ar1 i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Local copy of the register file and the AR1 history.
  srar1_pkg::mode_t mode_q;
  longint           offset_q;
  longint           slope_q;
  longint           ar_q;
  longint           prev_eta;
  bit               history_live;

  srar1_pkg::result_t residual_q[$];   // residuals still owed by the block, oldest first

  int unsigned requests_sent;
  int unsigned results_checked;
  int unsigned fault_results;
  int unsigned mismatches;
  int unsigned phases_run;
  int unsigned quiet_cycles;

  // Idle control shared between the request side and the result side.
  bit sender_quiet;
  bit receiver_quiet;
  bit hold_req;

  typedef struct {
    bit                    is_cfg;
    srar1_pkg::reg_index_t idx;
    logic [31:0]           data;
    srar1_pkg::sample_t    s;
    bit                    typed;
    srar1_pkg::result_t    golden;
  } script_row_t;

  script_row_t script[$];

  function automatic script_row_t blank_row();
    script_row_t row;
    row.is_cfg = 1'b0;
    row.idx    = srar1_pkg::REG_ERROR_MODE;
    row.data   = '0;
    row.s      = '0;
    row.typed  = 1'b0;
    row.golden = '0;
    return row;
  endfunction

  function automatic void script_cfg(input srar1_pkg::reg_index_t idx, input logic [31:0] data);
    script_row_t row;
    row        = blank_row();
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = data;
    script.insert(script.size(), row);
  endfunction

  // A golden residual is given only where it follows directly from the settings.
  function automatic void script_req(input logic [31:0] obs, input logic [31:0] sim,
                                     input logic [2:0] flags, input bit typed,
                                     input logic [31:0] res, input bit fault);
    script_row_t row;
    row                     = blank_row();
    row.s.observed          = obs;
    row.s.simulated         = sim;
    row.s.observed_missing  = flags[2];
    row.s.simulated_missing = flags[1];
    row.s.series_start      = flags[0];
    row.typed               = typed;
    row.golden.residual     = res;
    row.golden.divide_fault = fault;
    script.insert(script.size(), row);
  endfunction

  function automatic longint clamp_q(input longint v, inout bit hit);
    if (v > RES_HI) begin
      hit = 1'b1;
      return RES_HI;
    end
    if (v < RES_LO) begin
      hit = 1'b1;
      return RES_LO;
    end
    return v;
  endfunction

  // Work out the residual for one accepted request and advance the AR1 history.
  // Returns 0 when the request carries a missing sample and so owes no result.
  function automatic bit predict_residual(input srar1_pkg::sample_t s,
                                          output srar1_pkg::result_t r);
    longint obs;
    longint sim;
    longint diff;
    longint scale;
    longint eta;
    longint res;
    bit     fault;
    bit     spill;
    obs   = $signed(s.observed);
    sim   = $signed(s.simulated);
    fault = 1'b0;
    spill = 1'b0;
    r     = '0;
    // A series start drops the history even on a missing sample.
    if (s.series_start) history_live = 1'b0;
    if (s.observed_missing || s.simulated_missing) return 1'b0;
    diff = obs - sim;
    // Products floor by 2^16; the scale keeps its full width.
    case (mode_q)
      srar1_pkg::MODE_CONSTANT:     scale = offset_q;
      srar1_pkg::MODE_PROPORTIONAL: scale = (offset_q * sim) >>> srar1_pkg::FRAC_W;
      default:                      scale = offset_q + ((slope_q * sim) >>> srar1_pkg::FRAC_W);
    endcase
    if (scale == 0) begin
      fault = 1'b1;
      eta   = (diff > 0) ? RES_HI : ((diff < 0) ? RES_LO : 64'sd0);
    end else begin
      // Integer division truncates toward zero, as the divider does.
      eta = clamp_q((diff * 65536) / scale, fault);
    end
    res = eta;
    if (mode_q == srar1_pkg::MODE_LINEAR_AR1) begin
      // Overflow of the AR subtraction saturates but leaves divide_fault alone.
      if (history_live)
        res = clamp_q(eta - ((ar_q * prev_eta) >>> srar1_pkg::FRAC_W), spill);
      prev_eta     = eta;
      history_live = 1'b1;
    end
    r.residual     = res[31:0];
    r.divide_fault = fault;
    return 1'b1;
  endfunction

  // Mostly short gaps, some medium ones and a rare long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(30, 120);
  endfunction

  // Q16.16 operand: extremes, full range, mid range and small values.
  function automatic logic [31:0] pick_q();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return srar1_pkg::Q_MAX;
          1:       return srar1_pkg::Q_MIN;
          2:       return 32'h0000_0000;
          3:       return 32'h0001_0000;
          default: return 32'hffff_0000;
        endcase
      end
      1, 2, 3: return $urandom();
      4, 5:    return 32'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000;
      default: return 32'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000;
    endcase
  endfunction

  // AR coefficient: mostly within +-1.0, the rest anywhere.
  function automatic logic [31:0] pick_coef();
    if ($urandom_range(0, 9) < 7) return 32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000;
    return pick_q();
  endfunction

  // Series of kept samples with random content; a few missing flags and restarts.
  function automatic srar1_pkg::sample_t random_request();
    srar1_pkg::sample_t s;
    s.simulated = pick_q();
    if ($urandom_range(0, 9) < 3)
      s.observed = s.simulated + (32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000);
    else
      s.observed = pick_q();
    s.observed_missing  = ($urandom_range(0, 13) == 0);
    s.simulated_missing = ($urandom_range(0, 13) == 0);
    s.series_start      = ($urandom_range(0, 11) == 0);
    return s;
  endfunction

  // Offer one request, hold it until taken, then book the residual it owes.
  task automatic send_sample(input srar1_pkg::sample_t s, input bit typed,
                             input srar1_pkg::result_t golden);
    int unsigned        gap;
    srar1_pkg::result_t r;
    gap = sender_quiet ? 0 : idle_len();
    if (gap != 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample       <= s;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    requests_sent++;
    if (predict_residual(s, r)) residual_q.insert(residual_q.size(), typed ? golden : r);
  endtask

  // Drop valid, wait for every owed residual, then let a missing request drain.
  task automatic wait_idle();
    sample_valid <= 1'b0;
    while (residual_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Drive one register write; the caller lowers cfg_write after its last write.
  task automatic write_reg(input srar1_pkg::reg_index_t idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      srar1_pkg::REG_ERROR_MODE:     mode_q   = srar1_pkg::mode_t'(data[1:0]);
      srar1_pkg::REG_SCALE_OFFSET:   offset_q = $signed(data);
      srar1_pkg::REG_SCALE_SLOPE:    slope_q  = $signed(data);
      srar1_pkg::REG_AR_COEFFICIENT: ar_q     = $signed(data);
      default: ;
    endcase
  endtask

  // Program all four registers for one random phase and pick its idle pattern.
  task automatic set_up_phase(input int unsigned n);
    srar1_pkg::mode_t m;
    logic [31:0]      mode_word;
    logic [31:0]      off;
    logic [31:0]      slp;
    logic [31:0]      rho;
    m   = ($urandom_range(0, 5) > 3) ? srar1_pkg::MODE_LINEAR_AR1
                                     : srar1_pkg::mode_t'($urandom_range(0, 3));
    off = pick_q();
    slp = pick_q();
    rho = pick_coef();
    if (n < 4) m = srar1_pkg::mode_t'(n);
    // Extreme settings in two fixed phases.
    if (n == 4) begin
      m   = srar1_pkg::MODE_LINEAR_AR1;
      off = srar1_pkg::Q_MIN;
      slp = srar1_pkg::Q_MAX;
      rho = srar1_pkg::Q_MIN;
    end
    if (n == 5) begin
      m   = srar1_pkg::MODE_LINEAR;
      off = srar1_pkg::Q_MAX;
      slp = srar1_pkg::Q_MIN;
      rho = srar1_pkg::Q_MAX;
    end
    // Upper bits of the mode word are don't-care; toggle them now and then.
    mode_word       = $urandom_range(0, 1) ? $urandom() : 32'h0;
    mode_word[1:0]  = m;
    write_reg(srar1_pkg::REG_ERROR_MODE, mode_word);
    write_reg(srar1_pkg::REG_SCALE_OFFSET, off);
    write_reg(srar1_pkg::REG_SCALE_SLOPE, slp);
    write_reg(srar1_pkg::REG_AR_COEFFICIENT, rho);
    cfg_write <= 1'b0;
    // Phase 2 is the pressure phase: sender runs flat out into a long hold-off.
    sender_quiet   = (n % 5 == 1) || (n == 2);
    receiver_quiet = (n % 5 == 1) || (n % 5 == 3);
    if (n == 2) hold_req = 1'b1;
  endtask

  // Result side: random stall runs, a long hold-off on request, none when quiet.
  initial begin
    int unsigned len;
    bit          lvl;
    result_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        lvl      = 1'b1;
        len      = HOLD_CYCLES;
        quiet_cycles += HOLD_CYCLES;
      end else if (receiver_quiet) begin
        lvl = 1'b0;
        len = 1;
      end else begin
        lvl = ($urandom_range(0, 2) == 0);
        len = lvl ? idle_len() + 1 : $urandom_range(1, 10);
      end
      result_stall <= lvl;
      repeat (len) @(posedge clk);
    end
  end

  // Compare each accepted result with the oldest owed residual.
  srar1_pkg::result_t owed;
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (residual_q.size() == 0) begin
        $error("unexpected result: residual=%h divide_fault=%b",
               result.residual, result.divide_fault);
        mismatches++;
      end else begin
        owed = residual_q.pop_front();
        results_checked++;
        if (result.divide_fault) fault_results++;
        if (result.residual !== owed.residual) begin
          $error("residual: expected %h, got %h", owed.residual, result.residual);
          mismatches++;
        end
        if (result.divide_fault !== owed.divide_fault) begin
          $error("divide_fault: expected %b, got %b", owed.divide_fault, result.divide_fault);
          mismatches++;
        end
      end
    end
  end

  // Stop a hung run: count cycles without any handshake on either channel.
  int unsigned stuck_cycles;
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WATCHDOG) begin
        $display("watchdog: no handshake for %0d cycles, %0d residuals owed",
                 stuck_cycles, residual_q.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned target;
    rst            = 1'b1;
    sample_valid   = 1'b0;
    sample         = '0;
    cfg_write      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    sender_quiet   = 1'b1;
    receiver_quiet = 1'b1;
    hold_req       = 1'b0;
    mode_q         = srar1_pkg::MODE_CONSTANT;
    offset_q       = 64'sd65536;
    slope_q        = 0;
    ar_q           = 0;
    prev_eta       = 0;
    history_live   = 1'b0;

    // Reset settings: constant mode, scale 1.0, so the residual is the plain difference.
    script_req(32'h0005_0000, 32'h0002_0000, F_NONE, 1'b1, 32'h0003_0000, 1'b0);
    script_req(srar1_pkg::Q_MAX, srar1_pkg::Q_MIN, F_NONE, 1'b1, srar1_pkg::Q_MAX, 1'b1);
    script_req(srar1_pkg::Q_MIN, srar1_pkg::Q_MAX, F_NONE, 1'b1, srar1_pkg::Q_MIN, 1'b1);
    script_req(32'h0000_0000, 32'h0000_0000, F_NONE, 1'b1, 32'h0000_0000, 1'b0);
    script_req(32'h0001_0000, 32'h0000_0000, F_OBS_MISS, 1'b0, '0, 1'b0);
    script_req(32'h0001_0000, 32'h0000_0000, F_SIM_MISS | F_START, 1'b0, '0, 1'b0);
    // Zero scale: saturate by the sign of the difference, raise the flag.
    script_cfg(srar1_pkg::REG_SCALE_OFFSET, 32'h0000_0000);
    script_req(32'h0001_0000, 32'h0000_0000, F_NONE, 1'b1, srar1_pkg::Q_MAX, 1'b1);
    script_req(32'hffff_0000, 32'h0000_0000, F_NONE, 1'b1, srar1_pkg::Q_MIN, 1'b1);
    script_req(32'h0003_0000, 32'h0003_0000, F_NONE, 1'b1, 32'h0000_0000, 1'b1);
    // Proportional scale, 0.5 * simulated.
    script_cfg(srar1_pkg::REG_ERROR_MODE, 32'(srar1_pkg::MODE_PROPORTIONAL));
    script_cfg(srar1_pkg::REG_SCALE_OFFSET, 32'h0000_8000);
    script_req(32'h0003_0000, 32'h0002_0000, F_NONE, 1'b0, '0, 1'b0);
    script_req(32'h0002_0000, 32'h0000_0000, F_NONE, 1'b1, srar1_pkg::Q_MAX, 1'b1);
    script_req(srar1_pkg::Q_MIN, 32'hfff0_0000, F_NONE, 1'b0, '0, 1'b0);
    // Linear scale 0.5 - 0.5 * simulated: negative, then zero.
    script_cfg(srar1_pkg::REG_ERROR_MODE, 32'(srar1_pkg::MODE_LINEAR));
    script_cfg(srar1_pkg::REG_SCALE_SLOPE, 32'hffff_8000);
    script_req(32'h0001_0000, 32'h0004_0000, F_NONE, 1'b0, '0, 1'b0);
    script_req(32'h0001_0000, 32'h0001_0000, F_NONE, 1'b1, 32'h0000_0000, 1'b1);
    // AR1 with rho 0.5 and unit scale.
    script_cfg(srar1_pkg::REG_ERROR_MODE, 32'(srar1_pkg::MODE_LINEAR_AR1));
    script_cfg(srar1_pkg::REG_SCALE_OFFSET, 32'h0001_0000);
    script_cfg(srar1_pkg::REG_SCALE_SLOPE, 32'h0000_0000);
    script_cfg(srar1_pkg::REG_AR_COEFFICIENT, 32'h0000_8000);
    script_req(32'h0002_0000, 32'h0000_0000, F_START, 1'b1, 32'h0002_0000, 1'b0);
    script_req(32'h0001_0000, 32'h0000_0000, F_NONE, 1'b1, 32'h0000_0000, 1'b0);
    script_req(32'h0005_0000, 32'h0000_0000, F_OBS_MISS | F_START, 1'b0, '0, 1'b0);
    script_req(32'h0004_0000, 32'h0000_0000, F_NONE, 1'b1, 32'h0004_0000, 1'b0);
    // Most negative rho: the AR subtraction overflows without a divide fault.
    script_cfg(srar1_pkg::REG_AR_COEFFICIENT, srar1_pkg::Q_MIN);
    script_req(32'h0001_0000, 32'h0000_0000, F_NONE, 1'b1, srar1_pkg::Q_MAX, 1'b0);
    script_req(srar1_pkg::Q_MAX, srar1_pkg::Q_MIN, F_NONE, 1'b0, '0, 1'b0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table; settings only change once the block is idle.
    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        wait_idle();
        write_reg(script[i].idx, script[i].data);
        cfg_write <= 1'b0;
      end else begin
        send_sample(script[i].s, script[i].typed, script[i].golden);
      end
    end

    // Random phases, each with fresh settings and its own idle pattern.
    phase = 0;
    while (requests_sent < REQUEST_ITEMS) begin
      wait_idle();
      set_up_phase(phase);
      target = requests_sent + $urandom_range(60, 200);
      while (requests_sent < target && requests_sent < REQUEST_ITEMS)
        send_sample(random_request(), 1'b0, '0);
      phase++;
    end
    phases_run = phase;

    wait_idle();
    $display("covered %0d requests over %0d random setting phases and a directed table",
             requests_sent, phases_run);
    $display("checked %0d residuals, %0d with divide_fault; output held off %0d cycles",
             results_checked, fault_results, quiet_cycles);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
